>>> src/lsc_pkg.sv
// Shared types and constants for the LRU slot cache policy block.
package lsc_pkg;

  localparam int LSC_NUM_ENTRIES = 32;
  localparam int LSC_CAPACITY    = 3;
  localparam int LSC_STAMP_W     = 32;
  localparam int LSC_INDEX_W     = 8;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_LOADED    = 3'd1,
    ST_FAILED    = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_DISABLED  = 3'd4
  } lsc_status_t;

  typedef struct packed {
    logic [LSC_INDEX_W-1:0] request_index;
    logic                   fetch_ok;
  } lsc_req_t;

  typedef struct packed {
    lsc_status_t            status;
    logic                   evicted_valid;
    logic [LSC_INDEX_W-1:0] evicted_index;
  } lsc_rsp_t;

  // Victim search result handed from the scanner to the control.
  typedef struct packed {
    logic                   done;
    logic [LSC_INDEX_W-1:0] victim;
  } lsc_scan_t;

endpackage

>>> src/lsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/lsc_victim_scan.sv
// Sequential least-recently-used victim search over the stamp RAM.
module lsc_victim_scan import lsc_pkg::*; #(
  parameter int NUM_ENTRIES = LSC_NUM_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [NUM_ENTRIES-1:0]         resident,
  output logic [$clog2(NUM_ENTRIES)-1:0] rd_addr,
  input  logic [LSC_STAMP_W-1:0]         rd_data,
  output lsc_scan_t                      scan
);

  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_ENTRIES - 1);

  logic                   busy_r, busy_nxt;
  logic [IDX_W-1:0]       addr_r, addr_nxt;
  logic                   rv_r, rv_nxt;
  logic [IDX_W-1:0]       ridx_r, ridx_nxt;
  logic                   found_r, found_nxt;
  logic [LSC_STAMP_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]       victim_r, victim_nxt;
  logic                   done_r, done_nxt;

  assign rd_addr = addr_r;

  always_comb begin
    busy_nxt   = busy_r;
    addr_nxt   = addr_r;
    rv_nxt     = 1'b0;
    ridx_nxt   = ridx_r;
    found_nxt  = found_r;
    best_nxt   = best_r;
    victim_nxt = victim_r;
    done_nxt   = 1'b0;

    if (start) begin
      busy_nxt  = 1'b1;
      addr_nxt  = '0;
      found_nxt = 1'b0;
    end else if (busy_r) begin
      rv_nxt   = 1'b1;
      ridx_nxt = addr_r;
      if (addr_r == LAST) begin
        busy_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + IDX_W'(1);
      end
    end

    // read data for ridx_r arrives in the cycle after its address
    if (rv_r) begin
      if (resident[ridx_r] && (!found_r || rd_data < best_r)) begin
        found_nxt  = 1'b1;
        best_nxt   = rd_data;
        victim_nxt = ridx_r;
      end
      if (ridx_r == LAST) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      rv_r    <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
      addr_r  <= '0;
    end else begin
      busy_r  <= busy_nxt;
      rv_r    <= rv_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
      addr_r  <= addr_nxt;
    end
    ridx_r   <= ridx_nxt;
    best_r   <= best_nxt;
    victim_r <= victim_nxt;
  end

  assign scan.done   = done_r;
  assign scan.victim = LSC_INDEX_W'(victim_r);

endmodule

>>> src/lru_slot_cache_policy_core.sv
// Hit, miss below capacity, bad index and disabled: the result is registered in res_r,
// then moves to the output register from S_RES once the output is free.
// Miss at capacity: the victim scan reads one stamp per cycle from the RAM over all
// NUM_ENTRIES entries before the result is registered and moved to the output.
// One transaction in flight; the next is taken once the result moves to the output register.
// Synchronous active-low reset clears residency, counters and config;
// stamp RAM needs no clear since a stamp is read only for resident entries.
module lru_slot_cache_policy_core import lsc_pkg::*; #(
  parameter int NUM_ENTRIES = LSC_NUM_ENTRIES,
  parameter int CAPACITY    = LSC_CAPACITY
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lsc_req_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lsc_rsp_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
  localparam logic [31:0] CAP_V = 32'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RES  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   disabled_r;
  logic [NUM_ENTRIES-1:0] resident_r, resident_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [LSC_STAMP_W-1:0] use_cnt_r, use_cnt_nxt;
  logic [IDX_W-1:0]       req_idx_r, req_idx_nxt;
  logic                   req_ok_r, req_ok_nxt;
  lsc_rsp_t               res_r, res_nxt;
  lsc_rsp_t               out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [LSC_STAMP_W-1:0] ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [LSC_STAMP_W-1:0] ram_rdata;

  logic                   scan_start;
  lsc_scan_t              scan;

  logic                   acc;
  logic                   idx_ok;
  logic [IDX_W-1:0]       in_idx;
  logic [IDX_W-1:0]       victim;
  logic [LSC_STAMP_W-1:0] use_inc;
  logic                   full;

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign idx_ok    = {1'b0, in_data.request_index} < 9'(NUM_ENTRIES);
  assign in_idx    = in_data.request_index[IDX_W-1:0];
  assign victim    = scan.victim[IDX_W-1:0];
  assign use_inc   = use_cnt_r + 32'd1;
  assign full      = 32'(cnt_r) >= CAP_V;

  always_comb begin
    state_nxt     = state_r;
    resident_nxt  = resident_r;
    cnt_nxt       = cnt_r;
    use_cnt_nxt   = use_cnt_r;
    req_idx_nxt   = req_idx_r;
    req_ok_nxt    = req_ok_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = in_idx;
    ram_wdata     = use_inc;
    scan_start    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          res_nxt.evicted_valid = 1'b0;
          res_nxt.evicted_index = '0;
          state_nxt             = S_RES;
          if (disabled_r) begin
            res_nxt.status = ST_DISABLED;
          end else if (!idx_ok) begin
            res_nxt.status = ST_BAD_INDEX;
          end else begin
            use_cnt_nxt = use_inc;
            req_idx_nxt = in_idx;
            req_ok_nxt  = in_data.fetch_ok;
            if (resident_r[in_idx]) begin
              ram_we         = 1'b1;
              res_nxt.status = ST_HIT;
            end else if (full) begin
              scan_start = 1'b1;
              state_nxt  = S_SCAN;
            end else if (in_data.fetch_ok) begin
              ram_we               = 1'b1;
              resident_nxt[in_idx] = 1'b1;
              cnt_nxt              = cnt_r + CNT_W'(1);
              res_nxt.status       = ST_LOADED;
            end else begin
              res_nxt.status = ST_FAILED;
            end
          end
        end
      end
      S_SCAN: begin
        if (scan.done) begin
          resident_nxt[victim]  = 1'b0;
          res_nxt.evicted_valid = 1'b1;
          res_nxt.evicted_index = scan.victim;
          state_nxt             = S_RES;
          // victim never equals the request: the request was not resident
          if (req_ok_r) begin
            ram_we                  = 1'b1;
            ram_waddr               = req_idx_r;
            ram_wdata               = use_cnt_r;
            resident_nxt[req_idx_r] = 1'b1;
            res_nxt.status          = ST_LOADED;
          end else begin
            cnt_nxt        = cnt_r - CNT_W'(1);
            res_nxt.status = ST_FAILED;
          end
        end
      end
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      disabled_r  <= 1'b0;
      resident_r  <= '0;
      cnt_r       <= '0;
      use_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      resident_r  <= resident_nxt;
      cnt_r       <= cnt_nxt;
      use_cnt_r   <= use_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        disabled_r <= cfg_wdata;
      end
    end
    req_idx_r <= req_idx_nxt;
    req_ok_r  <= req_ok_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  lsc_ram #(
    .WIDTH(LSC_STAMP_W),
    .DEPTH(NUM_ENTRIES)
  ) u_stamp_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lsc_victim_scan #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_victim_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .resident(resident_r),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata),
    .scan    (scan)
  );

endmodule
